>>> design/ccpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccpc_pkg
// Shared types and constants of the chance-constrained polytope check.
// ----------------------------------------------------------------------------
package ccpc_pkg;

  localparam int unsigned MaxObstacles     = 16;
  localparam int unsigned FacesPerObstacle = 6;

  localparam logic signed [31:0] BoxHighQ16 = 32'sd6553600;
  localparam logic [28:0]        SmallVarQ48 = 29'd281474977;

  localparam logic [2:0] RegObstacleCount = 3'd0;
  localparam logic [2:0] RegMarginFactor  = 3'd1;
  localparam logic [2:0] RegBoundXLow     = 3'd2;
  localparam logic [2:0] RegBoundXHigh    = 3'd3;
  localparam logic [2:0] RegBoundYLow     = 3'd4;
  localparam logic [2:0] RegBoundYHigh    = 3'd5;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [4:0] NoObstacle = 5'd16;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StFetch,
    StLeftA,
    StLeftB,
    StSqA,
    StVarA,
    StSqB,
    StVarB,
    StSqC,
    StVarC,
    StSqrt,
    StRight,
    StCmp,
    StOut
  } state_e;

endpackage : ccpc_pkg
`default_nettype wire

>>> design/ccpc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccpc_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module ccpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : ccpc_ram
`default_nettype wire

>>> design/chance_constrained_polytope_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chance_constrained_polytope_check
// Checks a Gaussian query position against a table of polytope obstacles,
// one face at a time on a shared multiplier and a bit-serial square root.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_axis  | in  | tuser: operation; tdata: obstacle_index, face_index,
//          |     |   normal_x/y/z, plane_offset, pos_x/y, var_x/y
//  m_axis  | out | tdata: is_valid, out_of_bounds, failing_obstacle
//  apb     | in  | six registers at 4*i
//
// A load, an out-of-bounds query or a query with obstacle count zero goes
// straight to its result. Each face visited passes through read, fetch,
// 8 steps on one 34x32 multiplier, 32 square-root steps, margin multiply and
// compare. tready is low while an item is at work. A finished result waits in
// an output register; only the next finished result stalls on it.
// ----------------------------------------------------------------------------
module chance_constrained_polytope_check
  import ccpc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [0:0]   s_axis_tuser,  // operation
  // obstacle_index, face_index, normal_x, normal_y, normal_z, plane_offset,
  // pos_x, pos_y, var_x, var_y (lowest first), 1 pad bit
  input  wire logic [215:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // is_valid, out_of_bounds, failing_obstacle
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned Slots = MaxObstacles * FacesPerObstacle;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned ObsW  = $clog2(MaxObstacles + 1);
  localparam int unsigned FaceW = (FacesPerObstacle > 1) ? $clog2(FacesPerObstacle) : 1;

  // registers
  logic [4:0]         obstacle_count_q;
  logic signed [15:0] margin_factor_q;
  logic signed [31:0] bxl_q, bxh_q, byl_q, byh_q;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obstacle_count_q <= '0;
      margin_factor_q  <= '0;
      bxl_q <= '0;
      bxh_q <= BoxHighQ16;
      byl_q <= '0;
      byh_q <= BoxHighQ16;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        RegObstacleCount: obstacle_count_q <= pwdata[4:0];
        RegMarginFactor:  margin_factor_q  <= pwdata[15:0];
        RegBoundXLow:     bxl_q <= pwdata;
        RegBoundXHigh:    bxh_q <= pwdata;
        RegBoundYLow:     byl_q <= pwdata;
        RegBoundYHigh:    byh_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegObstacleCount: prdata = {27'd0, obstacle_count_q};
      RegMarginFactor:  prdata = {{16{margin_factor_q[15]}}, margin_factor_q};
      RegBoundXLow:     prdata = bxl_q;
      RegBoundXHigh:    prdata = bxh_q;
      RegBoundYLow:     prdata = byl_q;
      RegBoundYHigh:    prdata = byh_q;
      default:          prdata = '0;
    endcase
  end

  // input fields
  logic [3:0]         in_obs;
  logic [2:0]         in_face;
  logic [47:0]        in_normal;
  logic [31:0]        in_off;
  logic signed [31:0] in_px, in_py;
  assign in_obs    = s_axis_tdata[3:0];
  assign in_face   = s_axis_tdata[6:4];
  assign in_normal = s_axis_tdata[54:7];
  assign in_off    = s_axis_tdata[86:55];
  assign in_px     = s_axis_tdata[118:87];
  assign in_py     = s_axis_tdata[150:119];

  state_e state_q, state_d;
  logic s_xfer;
  assign s_xfer = s_axis_tvalid && s_axis_tready;

  // face memories
  logic [SlotW-1:0] wslot, rslot_q;
  logic             load_ok, load_we;
  logic [47:0]      nrm_rd;
  logic [31:0]      off_rd;
  assign wslot   = SlotW'(32'(in_obs) * FacesPerObstacle + 32'(in_face));
  assign load_ok = (32'(in_obs) < MaxObstacles) && (32'(in_face) < FacesPerObstacle);
  assign load_we = s_xfer && (s_axis_tuser[0] == OpLoad) && load_ok;

  ccpc_ram #(.Width(48), .Depth(Slots)) u_nrm (
    .clk_i, .we_i(load_we), .waddr_i(wslot),
    .wdata_i(in_normal), .raddr_i(rslot_q), .rdata_o(nrm_rd));
  ccpc_ram #(.Width(32), .Depth(Slots)) u_off (
    .clk_i, .we_i(load_we), .waddr_i(wslot),
    .wdata_i(in_off), .raddr_i(rslot_q), .rdata_o(off_rd));

  // query and working registers
  logic signed [31:0] px_q, py_q;
  logic [31:0]        vx_q, vy_q;
  logic [ObsW-1:0]    obs_q, count_q;
  logic [FaceW-1:0]   face_q;
  logic signed [15:0] a0_q, a1_q, a2_q;
  logic signed [31:0] b_q;
  logic signed [63:0] left_q, right_q;
  logic [31:0]        sq_q;
  logic [63:0]        acc_q;
  logic [33:0]        rem_q;
  logic [31:0]        root_q;
  logic [4:0]         step_q;
  logic               valid_q, oob_q;
  logic [4:0]         fail_q;
  logic               m_valid_q;
  logic [6:0]         res_q;
  logic               out_free;

  // shared multiplier: signed 34 x signed 32
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StLeftA: begin mul_a = {{18{a0_q[15]}}, a0_q}; mul_b = px_q; end
      StLeftB: begin mul_a = {{18{a1_q[15]}}, a1_q}; mul_b = py_q; end
      StSqA: begin mul_a = {{18{a0_q[15]}}, a0_q}; mul_b = {{16{a0_q[15]}}, a0_q}; end
      StVarA: begin mul_a = {2'b00, vx_q}; mul_b = sq_q; end
      StSqB: begin mul_a = {{18{a1_q[15]}}, a1_q}; mul_b = {{16{a1_q[15]}}, a1_q}; end
      StVarB: begin mul_a = {2'b00, vy_q}; mul_b = sq_q; end
      StSqC: begin mul_a = {{18{a2_q[15]}}, a2_q}; mul_b = {{16{a2_q[15]}}, a2_q}; end
      StVarC: begin mul_a = {5'd0, SmallVarQ48}; mul_b = sq_q; end
      StRight: begin
        mul_a = {2'b00, root_q};
        mul_b = {{16{margin_factor_q[15]}}, margin_factor_q};
      end
      default: ;
    endcase
  end

  // sqrt step: two radicand bits per cycle
  logic [35:0] rem_sh, trial, rem_diff;
  assign rem_sh   = {rem_q, acc_q[63:62]};
  assign trial    = {2'b00, root_q, 2'b01};
  assign rem_diff = rem_sh - trial;

  logic oob_now;
  assign oob_now = in_px < bxl_q || in_px > bxh_q || in_py < byl_q || in_py > byh_q ||
                   in_px < 0 || in_px > BoxHighQ16 || in_py < 0 || in_py > BoxHighQ16;

  logic last_face, last_obs, holds;
  assign last_face = face_q == FaceW'(FacesPerObstacle - 1);
  assign last_obs  = (obs_q + ObsW'(1)) >= count_q;
  assign holds     = (left_q <<< 4) >= right_q;

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (s_xfer) begin
          if ((s_axis_tuser[0] == OpLoad) || oob_now || (obstacle_count_q == '0)) begin
            state_d = StOut;
          end else begin
            state_d = StRead;
          end
        end
      end
      StRead:  state_d = StFetch;
      StFetch: state_d = StLeftA;
      StLeftA: state_d = StLeftB;
      StLeftB: state_d = StSqA;
      StSqA:   state_d = StVarA;
      StVarA:  state_d = StSqB;
      StSqB:   state_d = StVarB;
      StVarB:  state_d = StSqC;
      StSqC:   state_d = StVarC;
      StVarC:  state_d = StSqrt;
      StSqrt:  if (step_q == 5'd31) state_d = StRight;
      StRight: state_d = StCmp;
      StCmp: begin
        if (holds ? last_obs : last_face) state_d = StOut;
        else                              state_d = StRead;
      end
      StOut: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (s_xfer) begin
        px_q <= in_px; py_q <= in_py;
        vx_q <= s_axis_tdata[182:151]; vy_q <= s_axis_tdata[214:183];
        obs_q <= '0; face_q <= '0; rslot_q <= '0;
        count_q <= (32'(obstacle_count_q) > MaxObstacles) ? ObsW'(MaxObstacles)
                                                          : ObsW'(obstacle_count_q);
        valid_q <= (s_axis_tuser[0] == OpQuery) && !oob_now;
        oob_q   <= (s_axis_tuser[0] == OpQuery) && oob_now;
        fail_q  <= NoObstacle;
      end
      StFetch: begin
        a0_q <= nrm_rd[15:0]; a1_q <= nrm_rd[31:16]; a2_q <= nrm_rd[47:32];
        b_q  <= off_rd;
      end
      // z = 4.0 term is a shift by 18
      StLeftA: left_q <= $signed(mul_p[63:0]) + $signed({{30{a2_q[15]}}, a2_q, 18'd0});
      StLeftB: left_q <= left_q + $signed(mul_p[63:0]);
      StSqA, StSqB, StSqC: sq_q <= mul_p[31:0];
      StVarA: acc_q <= mul_p[63:0];
      StVarB: acc_q <= acc_q + mul_p[63:0];
      StVarC: begin
        acc_q  <= acc_q + {32'd0, mul_p[63:32]};
        rem_q  <= '0;
        root_q <= '0;
        step_q <= '0;
      end
      StSqrt: begin
        if (rem_sh >= trial) begin
          rem_q  <= rem_diff[33:0];
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_sh[33:0];
          root_q <= {root_q[30:0], 1'b0};
        end
        acc_q  <= {acc_q[61:0], 2'b00};
        step_q <= step_q + 5'd1;
      end
      StRight: right_q <= $signed({{14{b_q[31]}}, b_q, 18'd0}) + $signed(mul_p[63:0]);
      StCmp: begin
        if (holds) begin
          obs_q <= obs_q + ObsW'(1); face_q <= '0;
          rslot_q <= SlotW'(32'(obs_q + ObsW'(1)) * FacesPerObstacle);
        end else if (last_face) begin
          valid_q <= 1'b0; fail_q <= 5'(obs_q);
        end else begin
          face_q <= face_q + FaceW'(1); rslot_q <= rslot_q + SlotW'(1);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      res_q     <= '0;
    end else if (state_q == StOut && out_free) begin
      m_valid_q <= 1'b1;
      res_q     <= {fail_q, oob_q, valid_q};
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign s_axis_tready = state_q == StIdle;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

endmodule : chance_constrained_polytope_check
`default_nettype wire
